[rtl/source_tokenizer_top_assert.svh]
// Assertion macros for the source tokenizer checker.
`ifndef SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TOKENIZER_TOP_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define SRCTOK_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// check the consequent in the cycle after the antecedent
`define SRCTOK_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/srctok_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srctok_pkg;

	typedef enum logic [2:0] {
		SM_IDLE,
		SM_NUM,
		SM_IDENT,
		SM_EQ,
		SM_SLASH,
		SM_COMMENT,
		SM_DONE
	} scan_mode_t;

	typedef enum logic [4:0] {
		TK_NUMBER,
		TK_IDENT,
		TK_LET,
		TK_PRINT,
		TK_IF,
		TK_ELSE,
		TK_FOR,
		TK_TO,
		TK_PLUS,
		TK_MINUS,
		TK_STAR,
		TK_DIVIDE,
		TK_SEMI,
		TK_LBRACE,
		TK_RBRACE,
		TK_LPAREN,
		TK_RPAREN,
		TK_ASSIGN,
		TK_EQUAL,
		TK_GT,
		TK_LT,
		TK_INVALID,
		TK_END
	} tok_kind_t;

	localparam int KIND_BITS   = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int BURST_MAX   = 3;
	localparam int WINDOW_BITS = 40;

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_EQ         = 8'h3D;

	localparam logic [WINDOW_BITS-1:0] KW_LET   = 40'h00_006C_6574;
	localparam logic [WINDOW_BITS-1:0] KW_PRINT = 40'h70_7269_6E74;
	localparam logic [WINDOW_BITS-1:0] KW_IF    = 40'h00_0000_6966;
	localparam logic [WINDOW_BITS-1:0] KW_ELSE  = 40'h00_656C_7365;
	localparam logic [WINDOW_BITS-1:0] KW_FOR   = 40'h00_0066_6F72;
	localparam logic [WINDOW_BITS-1:0] KW_TO    = 40'h00_0000_746F;

	function automatic tok_kind_t ident_kind(input logic [WINDOW_BITS-1:0] win,
			input logic [2:0] len);
		tok_kind_t k;
		k = TK_IDENT;
		if (len == 3'd3 && win == KW_LET)   k = TK_LET;
		if (len == 3'd5 && win == KW_PRINT) k = TK_PRINT;
		if (len == 3'd2 && win == KW_IF)    k = TK_IF;
		if (len == 3'd4 && win == KW_ELSE)  k = TK_ELSE;
		if (len == 3'd3 && win == KW_FOR)   k = TK_FOR;
		if (len == 3'd2 && win == KW_TO)    k = TK_TO;
		return k;
	endfunction

	function automatic tok_kind_t single_kind(input logic [7:0] c);
		tok_kind_t k;
		case (c)
			"+": k = TK_PLUS;
			"-": k = TK_MINUS;
			"*": k = TK_STAR;
			";": k = TK_SEMI;
			"{": k = TK_LBRACE;
			"}": k = TK_RBRACE;
			"(": k = TK_LPAREN;
			")": k = TK_RPAREN;
			">": k = TK_GT;
			"<": k = TK_LT;
			default: k = TK_INVALID;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[rtl/srctok_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module srctok_front
	import srctok_pkg::*;
#(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16,
	parameter int LENGTH_BITS = 16,
	localparam int TW = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS,
	localparam int BW = 2 + BURST_MAX * TW
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             char_code,
	input  wire logic                   end_of_source,
	input  wire logic                   src_valid,
	output logic                        src_ready,
	output logic                        push,
	output logic [BW-1:0]               push_data,
	input  wire logic                   full
);

	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

	scan_mode_t               mode_q, mode_n;
	logic [LINE_BITS-1:0]     cur_line_q, cur_line_n, tok_line_q, tok_line_n, adv_line;
	logic [COLUMN_BITS-1:0]   cur_col_q, cur_col_n, tok_col_q, tok_col_n, adv_col;
	logic [LENGTH_BITS-1:0]   cnt_q, cnt_n, cnt_inc;
	logic [WINDOW_BITS-1:0]   win_q, win_n;
	logic [TW-1:0]            slot [BURST_MAX];
	logic [1:0]               n_tok;
	logic                     accept;
	logic                     is_digit, is_alpha, is_space, is_ident_ch;

	function automatic logic pending(input scan_mode_t m);
		return m == SM_NUM || m == SM_IDENT || m == SM_EQ || m == SM_SLASH;
	endfunction

	function automatic logic [TW-1:0] flush_tok(input scan_mode_t m,
			input logic [LINE_BITS-1:0] l, input logic [COLUMN_BITS-1:0] col,
			input logic [LENGTH_BITS-1:0] n, input logic [WINDOW_BITS-1:0] w);
		tok_kind_t                k;
		logic [LENGTH_BITS-1:0]   len;
		logic [2:0]               len3;
		len3 = (n > LENGTH_BITS'(5)) ? 3'd0 : n[2:0];
		len  = n;
		case (m)
			SM_NUM:   k = TK_NUMBER;
			SM_IDENT: k = ident_kind(w, len3);
			SM_EQ: begin
				k   = TK_ASSIGN;
				len = LENGTH_BITS'(1);
			end
			SM_SLASH: begin
				k   = TK_DIVIDE;
				len = LENGTH_BITS'(1);
			end
			default:  k = TK_INVALID;
		endcase
		return {k, l, col, len};
	endfunction

	assign src_ready = !full;
	assign accept    = src_valid && src_ready;

	assign is_digit    = char_code >= "0" && char_code <= "9";
	assign is_alpha    = (char_code >= "a" && char_code <= "z") ||
	                     (char_code >= "A" && char_code <= "Z");
	assign is_space    = char_code == " " || (char_code >= 8'd9 && char_code <= 8'd13);
	assign is_ident_ch = is_alpha || is_digit || char_code == CH_UNDERSCORE;

	assign cnt_inc = (cnt_q == LEN_MAX) ? cnt_q : cnt_q + LENGTH_BITS'(1);

	always_comb begin
		if (char_code == CH_LF) begin
			adv_line = (cur_line_q == LINE_MAX) ? cur_line_q : cur_line_q + LINE_BITS'(1);
			adv_col  = COLUMN_BITS'(1);
		end else begin
			adv_line = cur_line_q;
			adv_col  = (cur_col_q == COL_MAX) ? cur_col_q : cur_col_q + COLUMN_BITS'(1);
		end
	end

	always_comb begin
		logic consumed;
		logic reset_all;
		consumed   = 1'b0;
		reset_all  = 1'b0;
		mode_n     = mode_q;
		cur_line_n = cur_line_q;
		cur_col_n  = cur_col_q;
		tok_line_n = tok_line_q;
		tok_col_n  = tok_col_q;
		cnt_n      = cnt_q;
		win_n      = win_q;
		n_tok      = 2'd0;
		for (int i = 0; i < BURST_MAX; i++) begin
			slot[i] = '0;
		end

		if (mode_q == SM_DONE) begin
			reset_all = end_of_source;
		end else if (char_code == CH_NUL) begin
			if (pending(mode_q)) begin
				slot[n_tok] = flush_tok(mode_q, tok_line_q, tok_col_q, cnt_q, win_q);
				n_tok       = n_tok + 2'd1;
			end
			slot[n_tok] = {TK_END, cur_line_q, cur_col_q, LENGTH_BITS'(0)};
			n_tok       = n_tok + 2'd1;
			mode_n      = SM_DONE;
			reset_all   = end_of_source;
		end else begin
			case (mode_q)
				SM_NUM: begin
					if (is_digit) begin
						cnt_n    = cnt_inc;
						consumed = 1'b1;
					end
				end
				SM_IDENT: begin
					if (is_ident_ch) begin
						cnt_n    = cnt_inc;
						win_n    = {win_q[WINDOW_BITS-9:0], char_code};
						consumed = 1'b1;
					end
				end
				SM_EQ: begin
					if (char_code == CH_EQ) begin
						slot[n_tok] = {TK_EQUAL, tok_line_q, tok_col_q, LENGTH_BITS'(2)};
						n_tok       = n_tok + 2'd1;
						mode_n      = SM_IDLE;
						consumed    = 1'b1;
					end
				end
				SM_SLASH: begin
					if (char_code == CH_SLASH) begin
						mode_n   = SM_COMMENT;
						consumed = 1'b1;
					end
				end
				SM_COMMENT: begin
					if (char_code == CH_LF) begin
						mode_n = SM_IDLE;
					end
					consumed = 1'b1;
				end
				default: mode_n = SM_IDLE;
			endcase

			if (!consumed) begin
				if (pending(mode_q)) begin
					slot[n_tok] = flush_tok(mode_q, tok_line_q, tok_col_q, cnt_q, win_q);
					n_tok       = n_tok + 2'd1;
				end
				mode_n = SM_IDLE;
				if (is_space) begin
					mode_n = SM_IDLE;
				end else if (is_digit || is_alpha || char_code == CH_UNDERSCORE ||
				             char_code == CH_EQ || char_code == CH_SLASH) begin
					tok_line_n = cur_line_q;
					tok_col_n  = cur_col_q;
					cnt_n      = LENGTH_BITS'(1);
					win_n      = '0;
					if (is_digit) begin
						mode_n = SM_NUM;
					end else if (char_code == CH_EQ) begin
						mode_n = SM_EQ;
					end else if (char_code == CH_SLASH) begin
						mode_n = SM_SLASH;
					end else begin
						mode_n = SM_IDENT;
						win_n  = {{(WINDOW_BITS-8){1'b0}}, char_code};
					end
				end else begin
					slot[n_tok] = {single_kind(char_code), cur_line_q, cur_col_q,
					               LENGTH_BITS'(1)};
					n_tok       = n_tok + 2'd1;
				end
			end

			cur_line_n = adv_line;
			cur_col_n  = adv_col;

			if (end_of_source) begin
				if (pending(mode_n)) begin
					slot[n_tok] = flush_tok(mode_n, tok_line_n, tok_col_n, cnt_n, win_n);
					n_tok       = n_tok + 2'd1;
				end
				slot[n_tok] = {TK_END, adv_line, adv_col, LENGTH_BITS'(0)};
				n_tok       = n_tok + 2'd1;
				reset_all   = 1'b1;
			end
		end

		if (reset_all) begin
			mode_n     = SM_IDLE;
			cur_line_n = LINE_BITS'(1);
			cur_col_n  = COLUMN_BITS'(1);
			tok_line_n = LINE_BITS'(1);
			tok_col_n  = COLUMN_BITS'(1);
			cnt_n      = '0;
			win_n      = '0;
		end
	end

	assign push      = accept && (n_tok != 2'd0);
	assign push_data = {n_tok, slot[2], slot[1], slot[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= SM_IDLE;
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= COLUMN_BITS'(1);
			tok_line_q <= LINE_BITS'(1);
			tok_col_q  <= COLUMN_BITS'(1);
			cnt_q      <= '0;
			win_q      <= '0;
		end else if (accept) begin
			mode_q     <= mode_n;
			cur_line_q <= cur_line_n;
			cur_col_q  <= cur_col_n;
			tok_line_q <= tok_line_n;
			tok_col_q  <= tok_col_n;
			cnt_q      <= cnt_n;
			win_q      <= win_n;
		end
	end

endmodule

`default_nettype wire

[rtl/srctok_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module srctok_fifo
	import srctok_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push, do_pop;

	assign full    = count_q == (PW+1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/srctok_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module srctok_back
	import srctok_pkg::*;
#(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16,
	parameter int LENGTH_BITS = 16,
	localparam int TW = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS,
	localparam int BW = 2 + BURST_MAX * TW
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [BW-1:0]          bundle,
	input  wire logic                   empty,
	output logic                        pop,
	output logic [KIND_BITS-1:0]        token_kind,
	output logic [LINE_BITS-1:0]        start_line,
	output logic [COLUMN_BITS-1:0]      start_column,
	output logic [LENGTH_BITS-1:0]      token_length,
	output logic                        last_of_run,
	output logic                        tok_valid,
	input  wire logic                   tok_ready
);

	logic [1:0]    idx_q;
	logic [1:0]    n_tok;
	logic [TW-1:0] sel_tok;
	logic          load, is_last;
	logic          valid_q;
	logic [TW-1:0] tok_q;
	logic          last_q;

	assign n_tok = bundle[BW-1 -: 2];

	always_comb begin
		case (idx_q)
			2'd0:    sel_tok = bundle[0 +: TW];
			2'd1:    sel_tok = bundle[TW +: TW];
			default: sel_tok = bundle[2*TW +: TW];
		endcase
	end

	assign load    = !empty && (!valid_q || tok_ready);
	assign is_last = idx_q == (n_tok - 2'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (tok_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= sel_tok;
			last_q <= is_last;
		end
	end

	assign tok_valid    = valid_q;
	assign last_of_run  = last_q;
	assign token_length = tok_q[0 +: LENGTH_BITS];
	assign start_column = tok_q[LENGTH_BITS +: COLUMN_BITS];
	assign start_line   = tok_q[LENGTH_BITS+COLUMN_BITS +: LINE_BITS];
	assign token_kind   = tok_q[TW-1 -: KIND_BITS];

endmodule

`default_nettype wire

[rtl/source_tokenizer_top.sv]
// Channel   Handshake              Payload
// source    src_valid/src_ready    char_code, end_of_source
// token     tok_valid/tok_ready    token_kind, start_line, start_column,
//                                  token_length, last_of_run
//
// One source byte is taken per cycle while the bundle queue has room.
// A byte yields zero to three tokens; the output stage sends one token per
// cycle unless stalled by tok_ready, so bytes with several tokens can hold
// src_ready low once the four-entry queue fills. Tokens pass the bundle
// queue, then the output register. Reset is asynchronous; nothing is swept.
`timescale 1ns / 1ps
`default_nettype none

module source_tokenizer_top
	import srctok_pkg::*;
#(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16,
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             char_code,
	input  wire logic                   end_of_source,
	input  wire logic                   src_valid,
	output logic                        src_ready,
	output logic [KIND_BITS-1:0]        token_kind,
	output logic [LINE_BITS-1:0]        start_line,
	output logic [COLUMN_BITS-1:0]      start_column,
	output logic [LENGTH_BITS-1:0]      token_length,
	output logic                        last_of_run,
	output logic                        tok_valid,
	input  wire logic                   tok_ready
);

	localparam int TW = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS;
	localparam int BW = 2 + BURST_MAX * TW;

	logic          push, full, pop, empty;
	logic [BW-1:0] push_data, head_data;

	srctok_front #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_code     (char_code),
		.end_of_source (end_of_source),
		.src_valid     (src_valid),
		.src_ready     (src_ready),
		.push          (push),
		.push_data     (push_data),
		.full          (full)
	);

	srctok_fifo #(
		.WIDTH (BW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.rdata  (head_data),
		.empty  (empty)
	);

	srctok_back #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle       (head_data),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.start_line   (start_line),
		.start_column (start_column),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready)
	);

endmodule

`default_nettype wire

[rtl/srctok_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "source_tokenizer_top_assert.svh"

module srctok_checker
	import srctok_pkg::*;
#(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16,
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [KIND_BITS-1:0]   token_kind,
	input  wire logic [LINE_BITS-1:0]   start_line,
	input  wire logic [COLUMN_BITS-1:0] start_column,
	input  wire logic [LENGTH_BITS-1:0] token_length,
	input  wire logic                   last_of_run,
	input  wire logic                   tok_valid,
	input  wire logic                   tok_ready
);

	`SRCTOK_ASSERT_NEXT(a_tok_hold, clk, arst_n, tok_valid && !tok_ready,
		tok_valid && $stable(token_kind) && $stable(start_line) &&
		$stable(start_column) && $stable(token_length) && $stable(last_of_run),
		"token request changed while stalled")

	`SRCTOK_ASSERT_NOW(a_end_shape, clk, arst_n, tok_valid && token_kind == TK_END,
		token_length == '0 && last_of_run, "end token must be empty and close its run")

	`SRCTOK_ASSERT_NOW(a_body_len, clk, arst_n, tok_valid && token_kind != TK_END,
		token_length != '0, "non-end token with zero length")

	`SRCTOK_ASSERT_NOW(a_pos_nonzero, clk, arst_n, tok_valid,
		start_line != '0 && start_column != '0, "token position fell to zero")

endmodule

bind source_tokenizer_top srctok_checker #(
	.LINE_BITS   (LINE_BITS),
	.COLUMN_BITS (COLUMN_BITS),
	.LENGTH_BITS (LENGTH_BITS)
) u_srctok_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.token_kind   (token_kind),
	.start_line   (start_line),
	.start_column (start_column),
	.token_length (token_length),
	.last_of_run  (last_of_run),
	.tok_valid    (tok_valid),
	.tok_ready    (tok_ready)
);

`default_nettype wire
